### rtl/core/rs_enc_pkg.sv
// Package: field constants, generator polynomial and shared types for the RS(255,247) encoder.
`timescale 1ns / 1ps
`default_nettype none

package rs_enc_pkg;

  localparam int DATA_SYMBOLS   = 247;
  localparam int PARITY_SYMBOLS = 8;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [8:0] GF_POLY = 9'h11D;

  localparam int CNT_W     = $clog2(DATA_SYMBOLS + 1);
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SEL_W     = $clog2(PARITY_SYMBOLS + 1);
  localparam int PAR_IDX_W = $clog2(PARITY_SYMBOLS);

  typedef logic [PARITY_SYMBOLS-1:0][7:0] parity_t;
  typedef logic [PARITY_SYMBOLS:0][7:0]   gen_t;

  // One queued item: the data byte, whether it closes a codeword, and the parity then
  typedef struct packed {
    logic [7:0] data;
    logic       cw_end;
    parity_t    parity;
  } entry_t;

  // Multiply two field elements modulo the field polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] r;
    x = {1'b0, a};
    y = b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
      y = {1'b0, y[7:1]};
    end
    return r;
  endfunction

  // Expand the product of (x + alpha^i) for i = 1 .. PARITY_SYMBOLS
  function automatic gen_t expand_gen_coef();
    gen_t       g;
    logic [7:0] root;
    g    = '0;
    g[0] = 8'd1;
    root = 8'd1;
    for (int i = 1; i <= PARITY_SYMBOLS; i++) begin
      root = gf_mul(root, 8'd2);
      for (int j = i; j > 0; j--) begin
        g[j] = g[j-1] ^ gf_mul(g[j], root);
      end
      g[0] = gf_mul(g[0], root);
    end
    return g;
  endfunction

  localparam gen_t GEN_COEF = expand_gen_coef();

endpackage

`default_nettype wire

### rtl/core/rs_enc_front.sv
// Front end: byte-wide parity LFSR and data counter that build queue items.
`timescale 1ns / 1ps
`default_nettype none

module rs_enc_front
  import rs_enc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_symbol_i,
  output logic            enq_valid_o,
  input  wire logic       enq_ready_i,
  output entry_t          enq_entry_o
);

  parity_t          par_q, par_d, par_next;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       fb;
  logic             cw_end;
  logic             accept;

  assign full        = !enq_ready_i;
  assign enq_valid_o = push;
  assign accept      = push && enq_ready_i;
  assign cw_end      = (cnt_q == CNT_W'(DATA_SYMBOLS - 1));

  // Divide by the generator: shift all stages at once with feedback
  always_comb begin
    fb          = data_symbol_i ^ par_q[PARITY_SYMBOLS-1];
    par_next[0] = gf_mul(GEN_COEF[0], fb);
    for (int j = 1; j < PARITY_SYMBOLS; j++) begin
      par_next[j] = par_q[j-1] ^ gf_mul(GEN_COEF[j], fb);
    end
  end

  // Build the item; the parity snapshot matters only on the codeword's last byte
  always_comb begin
    enq_entry_o.data   = data_symbol_i;
    enq_entry_o.cw_end = cw_end;
    enq_entry_o.parity = par_next;
  end

  // Advance LFSR and counter; clear both after the last data byte
  always_comb begin
    par_d = par_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (cw_end) begin
        par_d = '0;
        cnt_d = '0;
      end else begin
        par_d = par_next;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= '0;
      cnt_q <= '0;
    end else begin
      par_q <= par_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rs_enc_queue.sv
// Short register queue between the encoder front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rs_enc_queue
  import rs_enc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   enq_valid_i,
  output logic        enq_ready_o,
  input  wire entry_t enq_entry_i,
  output logic        deq_valid_o,
  input  wire logic   deq_i,
  output entry_t      deq_entry_o
);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_enq, do_deq;

  assign enq_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign deq_valid_o = (cnt_q != '0);
  assign deq_entry_o = mem_q[rd_q];
  assign do_enq      = enq_valid_i && enq_ready_o;
  assign do_deq      = deq_i && deq_valid_o;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_enq) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_deq) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    priority if (do_enq && !do_deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_deq && !do_enq) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wr_q] <= enq_entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rs_enc_back.sv
// Back end: emits each queued data byte, then the parity bytes at a codeword end.
`timescale 1ns / 1ps
`default_nettype none

module rs_enc_back
  import rs_enc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   deq_valid_i,
  input  wire entry_t deq_entry_i,
  output logic        deq_o,
  output logic        empty,
  input  wire logic   pop,
  output logic [7:0]  out_symbol_o,
  output logic        is_parity_o,
  output logic        last_o
);

  // Zero selects the data byte; k selects the k-th parity byte, highest stage first
  logic [SEL_W-1:0] sel_q, sel_d;
  logic [SEL_W-1:0] ridx;
  logic             take;
  logic             item_done;

  assign empty = !deq_valid_i;
  assign take  = pop && deq_valid_i;
  assign ridx  = SEL_W'(PARITY_SYMBOLS) - sel_q;

  // Select the current result from the head item
  always_comb begin
    if (sel_q == '0) begin
      out_symbol_o = deq_entry_i.data;
      is_parity_o  = 1'b0;
    end else begin
      out_symbol_o = deq_entry_i.parity[ridx[PAR_IDX_W-1:0]];
      is_parity_o  = 1'b1;
    end
    last_o = (sel_q == SEL_W'(PARITY_SYMBOLS));
  end

  // Drop the head item after its final result
  assign item_done = ((sel_q == '0) && !deq_entry_i.cw_end) || last_o;
  assign deq_o     = take && item_done;

  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = item_done ? '0 : sel_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rs_255_247_systematic_encoder.sv
// Top level: RS(255,247) systematic encoder with queue interfaces on both sides.
// An accepted data byte is stored in the item queue, then shown on the result ports.
// Throughput: one data byte per cycle in while full is low, one result per cycle out
// while empty is low; 247 data bytes yield 255 results, 8 of them LFSR parity bytes.
// The 4-entry item queue lets the LFSR take bytes while parity bytes drain.
// Reset (asynchronous, active low) clears the LFSR, counters and queue; empty is high.
`timescale 1ns / 1ps
`default_nettype none

module rs_255_247_systematic_encoder
  import rs_enc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_symbol_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_symbol_o,
  output logic            is_parity_o,
  output logic            last_o
);

  logic   enq_valid, enq_ready, deq_valid, deq;
  entry_t enq_entry, deq_entry;

  rs_enc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_symbol_i (data_symbol_i),
    .enq_valid_o   (enq_valid),
    .enq_ready_i   (enq_ready),
    .enq_entry_o   (enq_entry)
  );

  rs_enc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_valid_i (enq_valid),
    .enq_ready_o (enq_ready),
    .enq_entry_i (enq_entry),
    .deq_valid_o (deq_valid),
    .deq_i       (deq),
    .deq_entry_o (deq_entry)
  );

  rs_enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .deq_valid_i  (deq_valid),
    .deq_entry_i  (deq_entry),
    .deq_o        (deq),
    .empty        (empty),
    .pop          (pop),
    .out_symbol_o (out_symbol_o),
    .is_parity_o  (is_parity_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

### rtl/core/rs_enc_checker.sv
// Checker: port-level assertions for the encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rs_enc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_symbol_o,
  input wire logic       is_parity_o,
  input wire logic       last_o
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_symbol_o) && $stable(is_parity_o)
                          && $stable(last_o)))
    else $error("stalled result changed");

  // The final byte of a codeword is a parity byte
  a_last_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> is_parity_o)
    else $error("last flag on a data byte");

  // Parity bytes of one codeword come back to back
  a_parity_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && is_parity_o && !last_o) |=> (!empty && is_parity_o))
    else $error("parity run broken");

  // A new codeword starts with data after the final parity byte
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && last_o) |=> (empty || !is_parity_o))
    else $error("parity byte after codeword end");

endmodule

bind rs_255_247_systematic_encoder rs_enc_checker u_rs_enc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .out_symbol_o  (out_symbol_o),
  .is_parity_o   (is_parity_o),
  .last_o        (last_o)
);

`default_nettype wire
